// ----- design/thick_line_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// thick_line_rasterizer assertion macros
// Shorthand for the clocked, reset-qualified properties used by the design.
// ----------------------------------------------------------------------------
`ifndef THICK_LINE_RASTERIZER_MACROS_SVH
`define THICK_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define TLR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define TLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tlr_pkg.sv -----
// ----------------------------------------------------------------------------
// tlr_pkg
// Shared widths, codes and the span descriptor of the thick line rasterizer.
// ----------------------------------------------------------------------------
package tlr_pkg;

    localparam int COORD_BITS = 10;
    localparam int PIX_BITS   = 12;
    localparam int HALF_BITS  = 3;
    localparam int CNT_BITS   = HALF_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int INC_BITS   = COORD_BITS + 3;
    localparam int DEC_BITS   = COORD_BITS + 4;

    localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(1);

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        SLOPE_X_RISE = 2'd0,
        SLOPE_Y_RISE = 2'd1,
        SLOPE_X_FALL = 2'd2,
        SLOPE_Y_FALL = 2'd3
    } slope_t;

    // One step's worth of work for the span emitter.
    typedef struct packed
    {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic                  xmajor;
        logic                  done;
        logic [HALF_BITS-1:0]  half;
    } span_t;

endpackage

// ----- design/tlr_in_if.sv -----
// ----------------------------------------------------------------------------
// tlr_in_if
// Command channel: start or advance transactions with line endpoints.
// ----------------------------------------------------------------------------
interface tlr_in_if;
    import tlr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_stop;
    logic [COORD_BITS-1:0] y_stop;

    modport source (output valid, op, x_start, y_start, x_stop, y_stop, input ready);
    modport sink   (input valid, op, x_start, y_start, x_stop, y_stop, output ready);
endinterface

// ----- design/tlr_out_if.sv -----
// ----------------------------------------------------------------------------
// tlr_out_if
// Pixel channel: one pixel per transaction with span and line markers.
// ----------------------------------------------------------------------------
interface tlr_out_if;
    import tlr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [PIX_BITS-1:0] pixel_x;
    logic signed [PIX_BITS-1:0] pixel_y;
    logic                       span_last;
    logic                       line_done;

    modport source (output valid, pixel_x, pixel_y, span_last, line_done, input ready);
    modport sink   (input valid, pixel_x, pixel_y, span_last, line_done, output ready);
endinterface

// ----- design/tlr_stepper.sv -----
// ----------------------------------------------------------------------------
// tlr_stepper
// Line setup and one midpoint step per command, producing span descriptors.
// ----------------------------------------------------------------------------
module tlr_stepper
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tlr_pkg::HALF_BITS-1:0] half_thickness,
    tlr_in_if.sink                        cmd,
    output logic                          span_valid,
    output tlr_pkg::span_t                span,
    input  logic                          span_take
);
    import tlr_pkg::*;

    logic [COORD_BITS-1:0]      cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]      cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]      major_end_reg, major_end_next;
    logic signed [DEC_BITS-1:0] decision_reg, decision_next;
    logic signed [INC_BITS-1:0] inc_straight_reg, inc_straight_next;
    logic signed [INC_BITS-1:0] inc_diagonal_reg, inc_diagonal_next;
    slope_t                     slope_case_reg, slope_case_next;
    logic                       active_reg, active_next;
    logic                       span_valid_reg, span_valid_next;
    span_t                      span_reg, span_next;

    logic                        accept;
    logic                        emit;
    logic signed [DIFF_BITS-1:0] dxr, dyr, dx, dy;
    logic [DIFF_BITS-1:0]        adx, ady;
    logic                        pos, xmajor, swap, straight, done;
    logic [COORD_BITS-1:0]       xs, ys, xe, ye;
    logic signed [DEC_BITS-1:0]  dxe, dye, inc_sel, s_dec, s_inc_s, s_inc_d;

    assign cmd.ready  = !span_valid_reg || span_take;
    assign accept     = cmd.valid && cmd.ready;
    assign span_valid = span_valid_reg;
    assign span       = span_reg;

    always_comb
    begin
        // Setup path for a start transaction.
        dxr = $signed({1'b0, cmd.x_stop}) - $signed({1'b0, cmd.x_start});
        dyr = $signed({1'b0, cmd.y_stop}) - $signed({1'b0, cmd.y_start});
        adx = dxr[DIFF_BITS-1] ? DIFF_BITS'(-dxr) : DIFF_BITS'(dxr);
        ady = dyr[DIFF_BITS-1] ? DIFF_BITS'(-dyr) : DIFF_BITS'(dyr);
        pos = ((dxr != '0) && (dyr != '0) && (dxr[DIFF_BITS-1] == dyr[DIFF_BITS-1]))
              || ((dxr == '0) && !dyr[DIFF_BITS-1] && (dyr != '0));
        xmajor = ady < adx;
        if (xmajor)
        begin
            swap = cmd.x_start > cmd.x_stop;
        end
        else if (pos)
        begin
            swap = cmd.y_start > cmd.y_stop;
        end
        else
        begin
            swap = !(cmd.y_start > cmd.y_stop);
        end
        xs = swap ? cmd.x_stop  : cmd.x_start;
        ys = swap ? cmd.y_stop  : cmd.y_start;
        xe = swap ? cmd.x_start : cmd.x_stop;
        ye = swap ? cmd.y_start : cmd.y_stop;
        dx = $signed({1'b0, xe}) - $signed({1'b0, xs});
        dy = $signed({1'b0, ye}) - $signed({1'b0, ys});
        dxe = {{(DEC_BITS-DIFF_BITS){dx[DIFF_BITS-1]}}, dx};
        dye = {{(DEC_BITS-DIFF_BITS){dy[DIFF_BITS-1]}}, dy};
        s_inc_d = (pos ? (dye - dxe) : (dye + dxe)) <<< 1;
        if (pos && xmajor)
        begin
            s_dec   = (dye <<< 1) - dxe;
            s_inc_s = dye <<< 1;
        end
        else if (pos)
        begin
            s_dec   = dye - (dxe <<< 1);
            s_inc_s = -(dxe <<< 1);
        end
        else if (xmajor)
        begin
            s_dec   = (dye <<< 1) + dxe;
            s_inc_s = dye <<< 1;
        end
        else
        begin
            s_dec   = dye + (dxe <<< 1);
            s_inc_s = dxe <<< 1;
        end

        // Default: hold all line state.
        cur_x_next        = cur_x_reg;
        cur_y_next        = cur_y_reg;
        major_end_next    = major_end_reg;
        decision_next     = decision_reg;
        inc_straight_next = inc_straight_reg;
        inc_diagonal_next = inc_diagonal_reg;
        slope_case_next   = slope_case_reg;
        active_next       = active_reg;
        straight          = 1'b0;
        inc_sel           = '0;
        done              = 1'b0;
        emit              = 1'b0;

        if (accept && (cmd.op == OP_START))
        begin
            emit              = 1'b1;
            cur_x_next        = xs;
            cur_y_next        = ys;
            decision_next     = s_dec;
            inc_straight_next = s_inc_s[INC_BITS-1:0];
            inc_diagonal_next = s_inc_d[INC_BITS-1:0];
            if (pos && xmajor)
            begin
                slope_case_next = SLOPE_X_RISE;
            end
            else if (pos)
            begin
                slope_case_next = SLOPE_Y_RISE;
            end
            else if (xmajor)
            begin
                slope_case_next = SLOPE_X_FALL;
            end
            else
            begin
                slope_case_next = SLOPE_Y_FALL;
            end
            major_end_next = xmajor ? xe : ye;
            done           = xmajor ? (xs == xe) : (ys == ye);
            active_next    = !done;
        end
        else if (accept && active_reg)
        begin
            emit = 1'b1;
            case (slope_case_reg)
                SLOPE_X_RISE:
                begin
                    straight   = decision_reg[DEC_BITS-1] || (decision_reg == '0);
                    cur_x_next = cur_x_reg + 1'b1;
                    cur_y_next = cur_y_reg + COORD_BITS'(!straight);
                end
                SLOPE_Y_RISE:
                begin
                    straight   = !decision_reg[DEC_BITS-1] && (decision_reg != '0);
                    cur_y_next = cur_y_reg + 1'b1;
                    cur_x_next = cur_x_reg + COORD_BITS'(!straight);
                end
                SLOPE_X_FALL:
                begin
                    straight   = !decision_reg[DEC_BITS-1];
                    cur_x_next = cur_x_reg + 1'b1;
                    cur_y_next = cur_y_reg - COORD_BITS'(!straight);
                end
                default:
                begin
                    straight   = decision_reg[DEC_BITS-1];
                    cur_y_next = cur_y_reg - 1'b1;
                    cur_x_next = cur_x_reg + COORD_BITS'(!straight);
                end
            endcase
            inc_sel = straight
                ? {{(DEC_BITS-INC_BITS){inc_straight_reg[INC_BITS-1]}}, inc_straight_reg}
                : {{(DEC_BITS-INC_BITS){inc_diagonal_reg[INC_BITS-1]}}, inc_diagonal_reg};
            decision_next = decision_reg + inc_sel;
            done = ((slope_case_reg == SLOPE_X_RISE) || (slope_case_reg == SLOPE_X_FALL))
                   ? (cur_x_next == major_end_reg) : (cur_y_next == major_end_reg);
            if (done)
            begin
                active_next = 1'b0;
            end
        end

        span_next.cx     = cur_x_next;
        span_next.cy     = cur_y_next;
        span_next.xmajor = (slope_case_next == SLOPE_X_RISE)
                           || (slope_case_next == SLOPE_X_FALL);
        span_next.done   = done;
        span_next.half   = half_thickness;

        if (emit)
        begin
            span_valid_next = 1'b1;
        end
        else if (span_take)
        begin
            span_valid_next = 1'b0;
        end
        else
        begin
            span_valid_next = span_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            major_end_reg    <= '0;
            decision_reg     <= '0;
            inc_straight_reg <= '0;
            inc_diagonal_reg <= '0;
            slope_case_reg   <= SLOPE_X_RISE;
            active_reg       <= 1'b0;
            span_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            major_end_reg    <= major_end_next;
            decision_reg     <= decision_next;
            inc_straight_reg <= inc_straight_next;
            inc_diagonal_reg <= inc_diagonal_next;
            slope_case_reg   <= slope_case_next;
            active_reg       <= active_next;
            span_valid_reg   <= span_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            span_reg <= span_next;
        end
    end

endmodule

// ----- design/tlr_span_emitter.sv -----
// ----------------------------------------------------------------------------
// tlr_span_emitter
// Walks a span descriptor and issues its pixels one per cycle while the pixel channel is ready.
// ----------------------------------------------------------------------------
module tlr_span_emitter
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           span_valid,
    input  tlr_pkg::span_t span,
    output logic           span_take,
    tlr_out_if.source      pix
);
    import tlr_pkg::*;

    logic                       busy_reg, busy_next;
    span_t                      cur_reg;
    logic [CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [PIX_BITS-1:0] pix_x_reg, pix_y_reg, pix_x_next, pix_y_next;
    logic                       last_reg, done_reg;

    logic                  issuing, last;
    logic [CNT_BITS-1:0]   cnt_inc;
    logic [HALF_BITS-1:0]  off;
    logic [PIX_BITS-1:0]   base_x, base_y, off_ext, moved;

    assign issuing   = busy_reg && (!out_valid_reg || pix.ready);
    assign last      = cnt_reg == {cur_reg.half, 1'b0};
    assign span_take = span_valid && (!busy_reg || (issuing && last));

    assign pix.valid     = out_valid_reg;
    assign pix.pixel_x   = pix_x_reg;
    assign pix.pixel_y   = pix_y_reg;
    assign pix.span_last = last_reg;
    assign pix.line_done = done_reg;

    always_comb
    begin
        // Order within a span: centre, then -1, +1, -2, +2 and so on.
        cnt_inc = cnt_reg + 1'b1;
        off     = cnt_inc[CNT_BITS-1:1];
        off_ext = {{(PIX_BITS-HALF_BITS){1'b0}}, off};
        base_x  = {{(PIX_BITS-COORD_BITS){1'b0}}, cur_reg.cx};
        base_y  = {{(PIX_BITS-COORD_BITS){1'b0}}, cur_reg.cy};
        moved   = cur_reg.xmajor ? base_y : base_x;
        moved   = cnt_reg[0] ? (moved - off_ext) : (moved + off_ext);
        pix_x_next = $signed(cur_reg.xmajor ? base_x : moved);
        pix_y_next = $signed(cur_reg.xmajor ? moved : base_y);

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (issuing)
        begin
            cnt_next = last ? '0 : cnt_inc;
            if (last)
            begin
                busy_next = span_take;
            end
        end
        else if (span_take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end

        if (issuing)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (span_take)
        begin
            cur_reg <= span;
        end
        if (issuing)
        begin
            pix_x_reg <= pix_x_next;
            pix_y_reg <= pix_y_next;
            last_reg  <= last;
            done_reg  <= cur_reg.done;
        end
    end

endmodule

// ----- design/thick_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// thick_line_rasterizer
// Midpoint line rasterizer that emits a thickened span of pixels per step.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   cmd       in         valid / ready        op, x_start, y_start, x_stop, y_stop
//   pix       out        valid / ready        pixel_x, pixel_y, span_last, line_done
//   cfg       in         cfg_we, no ready     cfg_wdata (half_thickness)
//
// A command transaction is set up or stepped in the cycle it is accepted and
// leaves a span descriptor, unless it is an advance with no active line; the
// emitter issues its 2*half_thickness+1 pixels (3 at reset) one per cycle while
// the pixel channel is ready. One span waits in the descriptor register while the
// previous one drains, and only then is the command input held off.
// rst_n clears the line state, both valid flags and sets half_thickness to 1.
//
module thick_line_rasterizer
(
    input  logic                          clk,
    input  logic                          rst_n,
    tlr_in_if.sink                        cmd,
    tlr_out_if.source                     pix,
    input  logic                          cfg_we,
    input  logic [tlr_pkg::HALF_BITS-1:0] cfg_wdata
);
    import tlr_pkg::*;

`include "thick_line_rasterizer_macros.svh"

    // Half thickness, sampled into each span descriptor when it is built.
    logic [HALF_BITS-1:0] half_thickness_reg, half_thickness_next;

    // Span descriptor handoff between the stepper and the emitter.
    logic  span_valid;
    span_t span;
    logic  span_take;

    assign half_thickness_next = cfg_we ? cfg_wdata : half_thickness_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_thickness_reg <= HALF_RESET;
        end
        else
        begin
            half_thickness_reg <= half_thickness_next;
        end
    end

    // Line setup and midpoint stepping; one descriptor per emitting command.
    tlr_stepper u_stepper
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .half_thickness (half_thickness_reg),
        .cmd            (cmd),
        .span_valid     (span_valid),
        .span           (span),
        .span_take      (span_take)
    );

    // Pixel serializer with its own output register.
    tlr_span_emitter u_emitter
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .span_valid (span_valid),
        .span       (span),
        .span_take  (span_take),
        .pix        (pix)
    );

    // A start transaction always produces a span.
    `TLR_ASSERT_NEXT(a_start_makes_span, cmd.valid && cmd.ready && (cmd.op == OP_START), span_valid, "start transaction left no span descriptor")

    // A waiting descriptor is never dropped before the emitter takes it.
    `TLR_ASSERT_NEXT(a_span_held, span_valid && !span_take, span_valid, "span descriptor lost while waiting")

    // Within a span the next pixel follows directly after a transfer.
    `TLR_ASSERT_NEXT(a_span_contiguous, pix.valid && pix.ready && !pix.span_last, pix.valid, "gap inside a span")

    // The emitter only takes a descriptor that is present.
    `TLR_ASSERT_SAME(a_take_valid, span_take, span_valid, "descriptor taken while none present")

endmodule
